@@ sv/ucs_pkg.sv @@
package ucs_pkg;

  localparam int MAX_URL_BYTES  = 32;
  localparam int IDX_W          = $clog2(MAX_URL_BYTES + 1);
  localparam int ADDR_W         = $clog2(MAX_URL_BYTES);
  localparam int MAX_BYTE_ITEMS = 32;
  localparam int CNT_W          = $clog2(MAX_BYTE_ITEMS + 1);
  localparam int NUM_SCHEMES    = 11;
  localparam int FIFO_DEPTH     = 2;
  localparam int FA_W           = $clog2(FIFO_DEPTH);
  localparam int FC_W           = $clog2(FIFO_DEPTH + 1);
  localparam int PORT_W         = 16;
  localparam int TDATA_W        = 40;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LBR   = 8'h5b;
  localparam logic [7:0] CH_RBR   = 8'h5d;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_QM    = 8'h3f;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [2:0] COMP_USER  = 3'd0;
  localparam logic [2:0] COMP_PASS  = 3'd1;
  localparam logic [2:0] COMP_HOST  = 3'd2;
  localparam logic [2:0] COMP_PATH  = 3'd3;
  localparam logic [2:0] COMP_QNAME = 3'd4;
  localparam logic [2:0] COMP_QVAL  = 3'd5;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_SCHEME  = 3'd1;
  localparam logic [2:0] STAT_PERCENT = 3'd2;
  localparam logic [2:0] STAT_PORT    = 3'd3;
  localparam logic [2:0] STAT_LONG    = 3'd4;

  localparam logic [3:0] SCH_NONE    = 4'd0;
  localparam logic [3:0] SCH_MAILTO  = 4'd7;
  localparam logic [3:0] SCH_NOTMUCH = 4'd8;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_SUM  = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] lower;
    logic       is_hex;
    logic [3:0] hex_val;
  } chr_t;

  typedef struct packed {
    chr_t chr;
    logic last;
  } qent_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SCHEME, ST_SL0, ST_SL1, ST_STEP, ST_FIND, ST_SEG,
    ST_SEGH1, ST_SEGH2, ST_DIGIT, ST_SLASH_OUT, ST_SUM
  } back_st_e;

  typedef enum logic [4:0] {
    PH_NS0, PH_NS1, PH_Q0, PH_Q1, PH_W0, PH_W1, PH_W2, PH_W3, PH_W4,
    PH_P0, PH_P1, PH_A0, PH_A1, PH_A2, PH_A3, PH_A4, PH_H0, PH_H1,
    PH_PT0, PH_PT1, PH_PT2, PH_HC, PH_E0, PH_E1, PH_E2, PH_E3, PH_E4,
    PH_E5, PH_SUM_OK
  } phase_e;

  function automatic logic [3:0] scheme_len(input logic [3:0] k);
    case (k)
      4'd0, 4'd1, 4'd4, 4'd5, 4'd9: scheme_len = 4'd4;
      4'd2, 4'd6, 4'd10:            scheme_len = 4'd5;
      4'd3:                         scheme_len = 4'd3;
      4'd7:                         scheme_len = 4'd6;
      4'd8:                         scheme_len = 4'd7;
      default:                      scheme_len = 4'd0;
    endcase
  endfunction

  // names left-aligned in a 7-character word
  function automatic logic [7:0] scheme_char(input logic [3:0] k, input logic [2:0] pos);
    logic [55:0] w;
    case (k)
      4'd0:    w = {"file", 24'h0};
      4'd1:    w = {"imap", 24'h0};
      4'd2:    w = {"imaps", 16'h0};
      4'd3:    w = {"pop", 32'h0};
      4'd4:    w = {"pops", 24'h0};
      4'd5:    w = {"news", 24'h0};
      4'd6:    w = {"snews", 16'h0};
      4'd7:    w = {"mailto", 8'h0};
      4'd8:    w = "notmuch";
      4'd9:    w = {"smtp", 24'h0};
      4'd10:   w = {"smtps", 16'h0};
      default: w = 56'h0;
    endcase
    scheme_char = w[55 - 8 * pos -: 8];
  endfunction

endpackage

@@ sv/ucs_front.sv @@
module ucs_front (
  input  logic [7:0]     s_axis_tdata,  // [7:0] byte_value
  input  logic           s_axis_tlast,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic           q_full_i,
  output logic           q_push_o,
  output ucs_pkg::qent_t q_data_o
);

  logic [7:0] b;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  always_comb begin
    q_data_o.last          = s_axis_tlast;
    q_data_o.chr.raw       = b;
    q_data_o.chr.lower     = (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
    q_data_o.chr.is_hex    = 1'b0;
    q_data_o.chr.hex_val   = 4'hf;
    if (b >= ucs_pkg::CH_0 && b <= ucs_pkg::CH_9) begin
      q_data_o.chr.is_hex  = 1'b1;
      q_data_o.chr.hex_val = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      q_data_o.chr.is_hex  = 1'b1;
      q_data_o.chr.hex_val = b[3:0] + 4'd9;
    end
  end

endmodule

@@ sv/ucs_fifo.sv @@
module ucs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ucs_pkg::qent_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ucs_pkg::qent_t rdata_o
);

  ucs_pkg::qent_t                mem_q [ucs_pkg::FIFO_DEPTH];
  logic [ucs_pkg::FA_W-1:0]      wp_q, rp_q;
  logic [ucs_pkg::FC_W-1:0]      cnt_q;
  logic                          do_push, do_pop;

  assign full_o  = cnt_q == ucs_pkg::FC_W'(ucs_pkg::FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [ucs_pkg::FA_W-1:0] wrap_inc(input logic [ucs_pkg::FA_W-1:0] p);
    wrap_inc = (p == ucs_pkg::FA_W'(ucs_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wrap_inc(wp_q);
      if (do_pop)  rp_q <= wrap_inc(rp_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= wdata_i;
  end

endmodule

@@ sv/ucs_back.sv @@
module ucs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_notmuch_i,
  input  logic                          q_valid_i,
  input  ucs_pkg::qent_t                q_data_i,
  output logic                          q_pop_o,
  output logic [ucs_pkg::TDATA_W-1:0]   m_axis_tdata,
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready
);

  localparam int IW = ucs_pkg::IDX_W;
  localparam int AW = ucs_pkg::ADDR_W;

  ucs_pkg::chr_t     buf_q [ucs_pkg::MAX_URL_BYTES];
  ucs_pkg::back_st_e st_q, st_d;
  ucs_pkg::phase_e   ph_q, ph_d;

  ucs_pkg::idx_t len_q, len_d, ptr_q, ptr_d, s_q, s_d, e_q, e_d, res_q, res_d;
  ucs_pkg::idx_t qb_q, qb_d, qe_q, qe_d, pb_q, pb_d, pe_q, pe_d;
  ucs_pkg::idx_t ub_q, ub_d, ue_q, ue_d, wb_q, wb_d, we_q, we_d;
  ucs_pkg::idx_t hb_q, hb_d, he_q, he_d, t_q, t_d, at_q, at_d;
  ucs_pkg::idx_t p_q, p_d, k_q, k_d, v_q, v_d;
  ucs_pkg::idx_t fb_q, fb_d, fe_q, fe_d, sge_q, sge_d;
  logic [7:0]    fch_q, fch_d;
  logic          frev_q, frev_d, sgem_q, sgem_d;
  logic [2:0]    sgc_q, sgc_d;
  logic [4:0]    sgn_q, sgn_d, qn_q, qn_d;
  logic [3:0]    hi_q, hi_d, code_q, code_d;
  logic          ovf_q, ovf_d, walk_q, walk_d;
  logic          has_q_q, has_q_d, has_p_q, has_p_d, has_w_q, has_w_d;
  logic [ucs_pkg::NUM_SCHEMES-1:0] mask_q, mask_d;
  logic [16:0]   port_q, port_d;
  logic [ucs_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [2:0]    sst_q, sst_d;
  logic          shh_q, shh_d;

  // output register
  logic          ov_q, ov_d, okind_q, okind_d;
  logic [2:0]    ocomp_q, ocomp_d, ostat_q, ostat_d;
  logic [4:0]    oqn_q, oqn_d;
  logic [7:0]    obyte_q, obyte_d;
  logic [3:0]    ocode_q, ocode_d;
  logic [15:0]   oport_q, oport_d;
  logic          ohh_q, ohh_d;

  logic          out_free;
  ucs_pkg::idx_t rd_addr;
  ucs_pkg::chr_t rd;
  logic          wr_en;

  assign out_free = !ov_q || m_axis_tready;
  assign rd       = buf_q[rd_addr[AW-1:0]];
  assign q_pop_o  = st_q == ucs_pkg::ST_LOAD;
  assign wr_en    = q_pop_o && q_valid_i && (len_q < IW'(ucs_pkg::MAX_URL_BYTES));

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = okind_q;
  assign m_axis_tdata  = {ohh_q, oport_q, ocode_q, ostat_q, obyte_q, oqn_q, ocomp_q};

  always_comb begin
    case (st_q)
      ucs_pkg::ST_SL0:   rd_addr = s_q;
      ucs_pkg::ST_SL1:   rd_addr = s_q + 1'b1;
      ucs_pkg::ST_STEP:  rd_addr = s_q;
      ucs_pkg::ST_FIND:  rd_addr = frev_q ? ptr_q - 1'b1 : ptr_q;
      ucs_pkg::ST_SEGH1: rd_addr = ptr_q + 1'b1;
      ucs_pkg::ST_SEGH2: rd_addr = ptr_q + 2'd2;
      default:           rd_addr = ptr_q;
    endcase
  end

  always_comb begin
    logic                lf, ls, put, fail;
    ucs_pkg::idx_t       lf_b, lf_e, ls_b, ls_e;
    logic [7:0]          lf_ch, put_b;
    logic                lf_rev, ls_m;
    logic [2:0]          ls_c, f_st;
    logic [4:0]          ls_n;
    logic [3:0]          f_code;
    logic                found;
    logic [3:0]          fcode;
    logic [20:0]         pn;
    logic [IW:0]         ptr2;

    st_d = st_q;     ph_d = ph_q;     len_d = len_q;  ptr_d = ptr_q;
    s_d = s_q;       e_d = e_q;       res_d = res_q;  qb_d = qb_q;
    qe_d = qe_q;     pb_d = pb_q;     pe_d = pe_q;    ub_d = ub_q;
    ue_d = ue_q;     wb_d = wb_q;     we_d = we_q;    hb_d = hb_q;
    he_d = he_q;     t_d = t_q;       at_d = at_q;    p_d = p_q;
    k_d = k_q;       v_d = v_q;       fb_d = fb_q;    fe_d = fe_q;
    sge_d = sge_q;   fch_d = fch_q;   frev_d = frev_q; sgem_d = sgem_q;
    sgc_d = sgc_q;   sgn_d = sgn_q;   qn_d = qn_q;    hi_d = hi_q;
    code_d = code_q; ovf_d = ovf_q;   walk_d = walk_q; has_q_d = has_q_q;
    has_p_d = has_p_q; has_w_d = has_w_q; mask_d = mask_q; port_d = port_q;
    cnt_d = cnt_q;   sst_d = sst_q;   shh_d = shh_q;
    ov_d = ov_q && !m_axis_tready;
    okind_d = okind_q; ocomp_d = ocomp_q; ostat_d = ostat_q; oqn_d = oqn_q;
    obyte_d = obyte_q; ocode_d = ocode_q; oport_d = oport_q; ohh_d = ohh_q;

    lf = 1'b0; ls = 1'b0; put = 1'b0; fail = 1'b0;
    lf_b = '0; lf_e = '0; ls_b = '0; ls_e = '0; lf_ch = '0; put_b = '0;
    lf_rev = 1'b0; ls_m = 1'b0; ls_c = '0; ls_n = '0;
    f_st = ucs_pkg::STAT_OK; f_code = ucs_pkg::SCH_NONE;
    found = 1'b0; fcode = '0; pn = '0;
    ptr2 = {1'b0, ptr_q} + 2'd2;

    case (st_q)
      ucs_pkg::ST_LOAD: begin
        if (q_valid_i) begin
          if (wr_en) len_d = len_q + 1'b1;
          else       ovf_d = 1'b1;
          if (q_data_i.last) begin
            ptr_d = '0; mask_d = '1; port_d = '0; hb_d = '0; he_d = '0;
            has_q_d = 1'b0; has_p_d = 1'b0; has_w_d = 1'b0; ub_d = '0; ue_d = '0;
            if (!wr_en || ovf_q) begin
              fail = 1'b1; f_st = ucs_pkg::STAT_LONG;
            end else begin
              st_d = ucs_pkg::ST_SCHEME;
            end
          end
        end
      end
      ucs_pkg::ST_SCHEME: begin
        if (ptr_q >= len_q) begin
          fail = 1'b1; f_st = ucs_pkg::STAT_SCHEME;
        end else if (rd.lower == ucs_pkg::CH_COLON) begin
          for (int k = ucs_pkg::NUM_SCHEMES - 1; k >= 0; k--) begin
            if (mask_q[k] && IW'(ucs_pkg::scheme_len(4'(k))) == ptr_q &&
                (4'(k) != ucs_pkg::SCH_NOTMUCH || en_notmuch_i)) begin
              found = 1'b1; fcode = 4'(k);
            end
          end
          if (!found) begin
            fail = 1'b1; f_st = ucs_pkg::STAT_SCHEME;
          end else begin
            code_d = fcode; s_d = ptr_q + 1'b1; st_d = ucs_pkg::ST_SL0;
          end
        end else begin
          for (int k = 0; k < ucs_pkg::NUM_SCHEMES; k++) begin
            mask_d[k] = mask_q[k] && (ptr_q < IW'(ucs_pkg::scheme_len(4'(k)))) &&
                        (ucs_pkg::scheme_char(4'(k), ptr_q[2:0]) == rd.lower);
          end
          ptr_d = ptr_q + 1'b1;
        end
      end
      ucs_pkg::ST_SL0: begin
        st_d = ucs_pkg::ST_STEP;
        if ({1'b0, s_q} + 2'd2 > {1'b0, len_q} || rd.raw != ucs_pkg::CH_SLASH)
          ph_d = ucs_pkg::PH_NS0;
        else
          st_d = ucs_pkg::ST_SL1;
      end
      ucs_pkg::ST_SL1: begin
        st_d = ucs_pkg::ST_STEP;
        if (rd.raw == ucs_pkg::CH_SLASH) begin
          s_d = s_q + 2'd2; e_d = len_q; ph_d = ucs_pkg::PH_Q0;
        end else begin
          ph_d = ucs_pkg::PH_NS0;
        end
      end
      ucs_pkg::ST_FIND: begin
        if (!frev_q) begin
          if (ptr_q >= fe_q) begin
            res_d = fe_q; st_d = ucs_pkg::ST_STEP;
          end else if (rd.raw == fch_q) begin
            res_d = ptr_q; st_d = ucs_pkg::ST_STEP;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end else begin
          if (ptr_q <= fb_q) begin
            res_d = fe_q; st_d = ucs_pkg::ST_STEP;
          end else if (rd.raw == fch_q) begin
            res_d = ptr_q - 1'b1; st_d = ucs_pkg::ST_STEP;
          end else begin
            ptr_d = ptr_q - 1'b1;
          end
        end
      end
      ucs_pkg::ST_SEG: begin
        if (ptr_q >= sge_q) begin
          st_d = ucs_pkg::ST_STEP;
        end else if (rd.raw == ucs_pkg::CH_PCT && ptr2 < {1'b0, sge_q}) begin
          st_d = ucs_pkg::ST_SEGH1;
        end else if (!sgem_q) begin
          if (rd.raw == ucs_pkg::CH_PCT) begin
            fail = 1'b1; f_st = ucs_pkg::STAT_PERCENT; f_code = code_q;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end else if (out_free) begin
          put = 1'b1; put_b = rd.raw; ptr_d = ptr_q + 1'b1;
        end
      end
      ucs_pkg::ST_SEGH1: begin
        hi_d = rd.hex_val;
        if (!sgem_q && !rd.is_hex) begin
          fail = 1'b1; f_st = ucs_pkg::STAT_PERCENT; f_code = code_q;
        end else begin
          st_d = ucs_pkg::ST_SEGH2;
        end
      end
      ucs_pkg::ST_SEGH2: begin
        if (!sgem_q) begin
          if (!rd.is_hex) begin
            fail = 1'b1; f_st = ucs_pkg::STAT_PERCENT; f_code = code_q;
          end else begin
            ptr_d = ptr_q + 2'd3; st_d = ucs_pkg::ST_SEG;
          end
        end else if (out_free) begin
          put = 1'b1; put_b = {hi_q, rd.hex_val};
          ptr_d = ptr_q + 2'd3; st_d = ucs_pkg::ST_SEG;
        end
      end
      ucs_pkg::ST_DIGIT: begin
        pn = {port_q, 3'b0} + {3'b0, port_q, 1'b0} + {13'b0, rd.raw - ucs_pkg::CH_0};
        if (ptr_q >= e_q) begin
          st_d = ucs_pkg::ST_STEP;
        end else if (rd.raw < ucs_pkg::CH_0 || rd.raw > ucs_pkg::CH_9 ||
                     pn > 21'h00ffff) begin
          fail = 1'b1; f_st = ucs_pkg::STAT_PORT; f_code = code_q;
        end else begin
          port_d = pn[16:0]; ptr_d = ptr_q + 1'b1;
        end
      end
      ucs_pkg::ST_SLASH_OUT: begin
        if (out_free) begin
          put = 1'b1; put_b = ucs_pkg::CH_SLASH; st_d = ucs_pkg::ST_STEP;
        end
      end
      ucs_pkg::ST_SUM: begin
        if (out_free) begin
          ov_d = 1'b1; okind_d = ucs_pkg::KIND_SUM; ocomp_d = '0; oqn_d = '0;
          obyte_d = '0; ostat_d = sst_q; ocode_d = code_q; oport_d = port_q[15:0];
          ohh_d = shh_q;
          st_d = ucs_pkg::ST_LOAD; len_d = '0; ovf_d = 1'b0; cnt_d = '0;
        end
      end
      ucs_pkg::ST_STEP: begin
        case (ph_q)
          ucs_pkg::PH_NS0: begin
            ls = 1'b1; ls_b = s_q; ls_e = len_q; ls_c = ucs_pkg::COMP_PATH;
            ph_d = ucs_pkg::PH_NS1;
          end
          ucs_pkg::PH_NS1: begin
            ls = 1'b1; ls_m = 1'b1; ls_b = s_q; ls_e = len_q;
            ls_c = ucs_pkg::COMP_PATH; ph_d = ucs_pkg::PH_SUM_OK;
          end
          ucs_pkg::PH_Q0: begin
            if (code_q == ucs_pkg::SCH_MAILTO || code_q == ucs_pkg::SCH_NOTMUCH) begin
              lf = 1'b1; lf_b = s_q; lf_e = e_q; lf_ch = ucs_pkg::CH_QM;
              lf_rev = 1'b1; ph_d = ucs_pkg::PH_Q1;
            end else begin
              ph_d = ucs_pkg::PH_P0;
            end
          end
          ucs_pkg::PH_Q1: begin
            if (res_q < e_q) begin
              has_q_d = 1'b1; qb_d = res_q + 1'b1; qe_d = e_q; e_d = res_q;
              walk_d = 1'b0; p_d = res_q + 1'b1; qn_d = '0; ph_d = ucs_pkg::PH_W0;
            end else begin
              ph_d = ucs_pkg::PH_P0;
            end
          end
          ucs_pkg::PH_W0: begin
            if (p_q >= qe_q) begin
              ph_d = walk_q ? ucs_pkg::PH_SUM_OK : ucs_pkg::PH_P0;
            end else begin
              lf = 1'b1; lf_b = p_q; lf_e = qe_q; lf_ch = ucs_pkg::CH_AMP;
              ph_d = ucs_pkg::PH_W1;
            end
          end
          ucs_pkg::PH_W1: begin
            k_d = res_q; lf = 1'b1; lf_b = p_q; lf_e = res_q; lf_ch = ucs_pkg::CH_EQ;
            ph_d = ucs_pkg::PH_W2;
          end
          ucs_pkg::PH_W2: begin
            v_d = res_q; ls = 1'b1; ls_m = walk_q; ls_b = p_q; ls_e = res_q;
            ls_c = ucs_pkg::COMP_QNAME; ls_n = qn_q; ph_d = ucs_pkg::PH_W3;
          end
          ucs_pkg::PH_W3: begin
            ph_d = ucs_pkg::PH_W4;
            if (v_q < k_q) begin
              ls = 1'b1; ls_m = walk_q; ls_b = v_q + 1'b1; ls_e = k_q;
              ls_c = ucs_pkg::COMP_QVAL; ls_n = qn_q;
            end
          end
          ucs_pkg::PH_W4: begin
            qn_d = qn_q + 1'b1;
            if (k_q >= qe_q) begin
              ph_d = walk_q ? ucs_pkg::PH_SUM_OK : ucs_pkg::PH_P0;
            end else begin
              p_d = k_q + 1'b1; ph_d = ucs_pkg::PH_W0;
            end
          end
          ucs_pkg::PH_P0: begin
            lf = 1'b1; lf_b = s_q; lf_e = e_q; lf_ch = ucs_pkg::CH_SLASH;
            ph_d = ucs_pkg::PH_P1;
          end
          ucs_pkg::PH_P1: begin
            ph_d = ucs_pkg::PH_A0;
            if (res_q < e_q) begin
              has_p_d = 1'b1; pb_d = res_q + 1'b1; pe_d = e_q; e_d = res_q;
              ls = 1'b1; ls_b = res_q + 1'b1; ls_e = e_q; ls_c = ucs_pkg::COMP_PATH;
            end
          end
          ucs_pkg::PH_A0: begin
            lf = 1'b1; lf_b = s_q; lf_e = e_q; lf_ch = ucs_pkg::CH_AT; lf_rev = 1'b1;
            ph_d = ucs_pkg::PH_A1;
          end
          ucs_pkg::PH_A1: begin
            if (res_q < e_q) begin
              at_d = res_q; lf = 1'b1; lf_b = s_q; lf_e = res_q;
              lf_ch = ucs_pkg::CH_COLON; ph_d = ucs_pkg::PH_A2;
            end else begin
              ph_d = ucs_pkg::PH_H0;
            end
          end
          ucs_pkg::PH_A2: begin
            ub_d = s_q; ue_d = res_q; ph_d = ucs_pkg::PH_A3;
            if (res_q < at_q) begin
              has_w_d = 1'b1; wb_d = res_q + 1'b1; we_d = at_q;
              ls = 1'b1; ls_b = res_q + 1'b1; ls_e = at_q; ls_c = ucs_pkg::COMP_PASS;
            end
          end
          ucs_pkg::PH_A3: begin
            ls = 1'b1; ls_b = ub_q; ls_e = ue_q; ls_c = ucs_pkg::COMP_USER;
            ph_d = ucs_pkg::PH_A4;
          end
          ucs_pkg::PH_A4: begin
            s_d = at_q + 1'b1; ph_d = ucs_pkg::PH_H0;
          end
          ucs_pkg::PH_H0: begin
            hb_d = s_q; he_d = e_q; t_d = s_q; ph_d = ucs_pkg::PH_PT0;
            if (s_q < e_q && rd.raw == ucs_pkg::CH_LBR) begin
              lf = 1'b1; lf_b = s_q + 1'b1; lf_e = e_q; lf_ch = ucs_pkg::CH_RBR;
              ph_d = ucs_pkg::PH_H1;
            end
          end
          ucs_pkg::PH_H1: begin
            if (res_q < e_q) begin
              hb_d = s_q + 1'b1; he_d = res_q; t_d = res_q + 1'b1;
            end
            ph_d = ucs_pkg::PH_PT0;
          end
          ucs_pkg::PH_PT0: begin
            lf = 1'b1; lf_b = t_q; lf_e = e_q; lf_ch = ucs_pkg::CH_COLON;
            ph_d = ucs_pkg::PH_PT1;
          end
          ucs_pkg::PH_PT1: begin
            if (res_q < e_q) begin
              ptr_d = res_q + 1'b1; st_d = ucs_pkg::ST_DIGIT; ph_d = ucs_pkg::PH_PT2;
            end else begin
              ph_d = ucs_pkg::PH_HC;
            end
          end
          ucs_pkg::PH_PT2: begin
            if (t_q == s_q) he_d = res_q;
            ph_d = ucs_pkg::PH_HC;
          end
          ucs_pkg::PH_HC: begin
            ph_d = ucs_pkg::PH_E0;
            if (he_q > hb_q) begin
              ls = 1'b1; ls_b = hb_q; ls_e = he_q; ls_c = ucs_pkg::COMP_HOST;
            end
          end
          ucs_pkg::PH_E0: begin
            ls = 1'b1; ls_m = 1'b1; ls_b = ub_q; ls_e = ue_q; ls_c = ucs_pkg::COMP_USER;
            ph_d = ucs_pkg::PH_E1;
          end
          ucs_pkg::PH_E1: begin
            ph_d = ucs_pkg::PH_E2;
            if (has_w_q) begin
              ls = 1'b1; ls_m = 1'b1; ls_b = wb_q; ls_e = we_q;
              ls_c = ucs_pkg::COMP_PASS;
            end
          end
          ucs_pkg::PH_E2: begin
            ls = 1'b1; ls_m = 1'b1; ls_b = hb_q; ls_e = he_q; ls_c = ucs_pkg::COMP_HOST;
            ph_d = ucs_pkg::PH_E3;
          end
          ucs_pkg::PH_E3: begin
            if (!has_p_q) begin
              ph_d = ucs_pkg::PH_E5;
            end else begin
              ph_d = ucs_pkg::PH_E4;
              if (he_q <= hb_q) st_d = ucs_pkg::ST_SLASH_OUT;
            end
          end
          ucs_pkg::PH_E4: begin
            ls = 1'b1; ls_m = 1'b1; ls_b = pb_q; ls_e = pe_q; ls_c = ucs_pkg::COMP_PATH;
            ph_d = ucs_pkg::PH_E5;
          end
          ucs_pkg::PH_E5: begin
            if (has_q_q) begin
              walk_d = 1'b1; p_d = qb_q; qn_d = '0; ph_d = ucs_pkg::PH_W0;
            end else begin
              ph_d = ucs_pkg::PH_SUM_OK;
            end
          end
          ucs_pkg::PH_SUM_OK: begin
            sst_d = ucs_pkg::STAT_OK; shh_d = he_q > hb_q; st_d = ucs_pkg::ST_SUM;
          end
          default: st_d = ucs_pkg::ST_LOAD;
        endcase
      end
      default: st_d = ucs_pkg::ST_LOAD;
    endcase

    if (lf) begin
      fb_d = lf_b; fe_d = lf_e; fch_d = lf_ch; frev_d = lf_rev;
      ptr_d = lf_rev ? lf_e : lf_b; st_d = ucs_pkg::ST_FIND;
    end
    if (ls) begin
      ptr_d = ls_b; sge_d = ls_e; sgc_d = ls_c; sgn_d = ls_n; sgem_d = ls_m;
      st_d = ucs_pkg::ST_SEG;
    end
    if (put && cnt_q < ucs_pkg::CNT_W'(ucs_pkg::MAX_BYTE_ITEMS)) begin
      cnt_d = cnt_q + 1'b1; ov_d = 1'b1; okind_d = ucs_pkg::KIND_BYTE;
      ocomp_d = sgc_q; oqn_d = sgn_q; obyte_d = put_b; ostat_d = ucs_pkg::STAT_OK;
      ocode_d = '0; oport_d = '0; ohh_d = 1'b0;
      if (st_q == ucs_pkg::ST_SLASH_OUT) begin
        ocomp_d = ucs_pkg::COMP_PATH; oqn_d = '0;
      end
    end
    if (fail) begin
      sst_d = f_st; code_d = f_code; port_d = '0; shh_d = 1'b0;
      st_d = ucs_pkg::ST_SUM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ucs_pkg::ST_LOAD;
      ph_q  <= ucs_pkg::PH_NS0;
      len_q <= '0;
      ovf_q <= 1'b0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      ph_q  <= ph_d;
      len_q <= len_d;
      ovf_q <= ovf_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) buf_q[len_q[AW-1:0]] <= q_data_i.chr;
    ptr_q <= ptr_d;   s_q <= s_d;       e_q <= e_d;       res_q <= res_d;
    qb_q <= qb_d;     qe_q <= qe_d;     pb_q <= pb_d;     pe_q <= pe_d;
    ub_q <= ub_d;     ue_q <= ue_d;     wb_q <= wb_d;     we_q <= we_d;
    hb_q <= hb_d;     he_q <= he_d;     t_q <= t_d;       at_q <= at_d;
    p_q <= p_d;       k_q <= k_d;       v_q <= v_d;       fb_q <= fb_d;
    fe_q <= fe_d;     sge_q <= sge_d;   fch_q <= fch_d;   frev_q <= frev_d;
    sgem_q <= sgem_d; sgc_q <= sgc_d;   sgn_q <= sgn_d;   qn_q <= qn_d;
    hi_q <= hi_d;     code_q <= code_d; walk_q <= walk_d; has_q_q <= has_q_d;
    has_p_q <= has_p_d; has_w_q <= has_w_d; mask_q <= mask_d; port_q <= port_d;
    sst_q <= sst_d;   shh_q <= shh_d;
    okind_q <= okind_d; ocomp_q <= ocomp_d; ostat_q <= ostat_d; oqn_q <= oqn_d;
    obyte_q <= obyte_d; ocode_q <= ocode_d; oport_q <= oport_d; ohh_q <= ohh_d;
  end

endmodule

@@ sv/url_component_splitter.sv @@
// URL component splitter. Takes one URL as a stream of raw bytes (one
// request per byte, last byte flagged by tlast), buffers up to 32 bytes and,
// after the last byte, splits it into user, password, host, path and query
// name/value parts, percent-decodes them and sends each decoded byte as a
// tagged request (tuser = 0), closed by one summary request (tuser = 1,
// tlast = 1) with status, scheme code, port and host flag. On any error or
// overlong input only the summary is sent. Bytes load one per cycle through
// a two-entry queue, so the input keeps flowing while the parser is busy
// until the queue fills. Parsing is done by a sequencer that reads the
// buffer one byte per cycle while the sink is not stalling output: each
// delimiter search, escape check and decode pass walks its span once, so
// the time spent on one URL grows with its length and the number of
// passes. The notmuch scheme is accepted only while the enable register
// is set; write it only when idle.
module url_component_splitter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config: enable_notmuch
  input  logic                        cfg_valid_i,
  input  logic                        cfg_data_i,
  output logic                        cfg_ready_o,
  // input bytes
  input  logic [7:0]                  s_axis_tdata,  // [7:0] byte_value
  input  logic                        s_axis_tlast,  // last_byte
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // results
  output logic [ucs_pkg::TDATA_W-1:0] m_axis_tdata,  // [2:0] component, [7:3] query_number,
                                                     // [15:8] decoded_byte, [18:16] status,
                                                     // [22:19] scheme_code,
                                                     // [38:23] port_number, [39] has_host
  output logic                        m_axis_tuser,  // item_kind
  output logic                        m_axis_tlast,  // last_result
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready
);

  logic           en_q;
  logic           q_push, q_full, q_pop, q_valid;
  ucs_pkg::qent_t q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) en_q <= 1'b0;
    else if (cfg_valid_i) en_q <= cfg_data_i;
  end

  // front: accept and classify bytes
  ucs_front u_front (
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  ucs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  // back: buffer, parse, decode, emit
  ucs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_notmuch_i  (en_q),
    .q_valid_i     (q_valid),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

import ucs_pkg::*;

// one result request, unpacked
typedef struct {
  bit        kind;
  bit [2:0]  comp;
  bit [4:0]  qnum;
  bit [7:0]  dbyte;
  bit [2:0]  status;
  bit [3:0]  scheme;
  bit [15:0] port;
  bit        has_host;
  bit        lst;
} url_item_t;

// Splits URLs the way the block should and holds the expected requests.
class url_scoreboard;
  bit [7:0]  text_mem[MAX_URL_BYTES];
  int        loaded;
  bit        overflow;
  bit        notmuch_on;
  url_item_t expected_q[$];
  url_item_t run_q[$];
  int        errors;
  string     scheme_names[NUM_SCHEMES] = '{"file", "imap", "imaps", "pop", "pops", "news",
                                           "snews", "mailto", "notmuch", "smtp", "smtps"};

  function void put(bit kind, bit [2:0] comp, bit [4:0] qn, bit [7:0] b, bit [2:0] st,
                    bit [3:0] sc, bit [15:0] port, bit hh);
    url_item_t r;
    r.kind = kind; r.comp = comp; r.qnum = qn; r.dbyte = b; r.status = st;
    r.scheme = sc; r.port = port; r.has_host = hh; r.lst = kind;
    if (run_q.size() < MAX_BYTE_ITEMS + 1) run_q.push_back(r);
  endfunction

  function void put_byte(bit [2:0] comp, int qn, bit [7:0] b);
    if (run_q.size() < MAX_BYTE_ITEMS) put(KIND_BYTE, comp, qn[4:0], b, STAT_OK, 0, 0, 0);
  endfunction

  function void fail(bit [2:0] st, bit [3:0] sc);
    run_q.delete();
    put(KIND_SUM, COMP_USER, 0, 0, st, sc, 0, 0);
  endfunction

  function int hexv(bit [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function int find_first(int b, int e, bit [7:0] ch);
    for (int i = b; i < e; i++) if (text_mem[i] == ch) return i;
    return e;
  endfunction

  function int find_last(int b, int e, bit [7:0] ch);
    for (int i = e - 1; i >= b; i--) if (text_mem[i] == ch) return i;
    return e;
  endfunction

  // every '%' needs two hex digits inside [b,e)
  function bit escapes_ok(int b, int e);
    int i;
    i = b;
    while (i < e) begin
      if (text_mem[i] == CH_PCT) begin
        if (i + 2 >= e || hexv(text_mem[i+1]) < 0 || hexv(text_mem[i+2]) < 0) return 0;
        i += 3;
      end else begin
        i++;
      end
    end
    return 1;
  endfunction

  function void decode_span(int b, int e, bit [2:0] comp, int qn);
    int i;
    int hi, lo;
    i = b;
    while (i < e) begin
      if (text_mem[i] == CH_PCT && i + 2 < e) begin
        hi = hexv(text_mem[i+1]);
        lo = hexv(text_mem[i+2]);
        put_byte(comp, qn, {hi[3:0], lo[3:0]});
        i += 3;
      end else begin
        put_byte(comp, qn, text_mem[i]);
        i++;
      end
    end
  endfunction

  // check-only or decode pass over the query pairs
  function bit query_pass(int b, int e, bit emit);
    int p, qn, k, v;
    p = b; qn = 0;
    while (p < e) begin
      k = find_first(p, e, CH_AMP);
      v = find_first(p, k, CH_EQ);
      if (!emit) begin
        if (v < k && !escapes_ok(v + 1, k)) return 0;
        if (!escapes_ok(p, v)) return 0;
      end else begin
        decode_span(p, v, COMP_QNAME, qn);
        if (v < k) decode_span(v + 1, k, COMP_QVAL, qn);
      end
      qn++;
      if (k >= e) break;
      p = k + 1;
    end
    return 1;
  endfunction

  function void split_url(int len);
    int colon, code, s, e, t, rb, pc, c2;
    int qb, qe, pb, pe, ub, ue, wb, we, hb, he;
    int unsigned port;
    bit has_q, has_p, has_w, same;
    bit [7:0] c;
    string nm;
    has_q = 0; has_p = 0; has_w = 0; port = 0;
    qb = 0; qe = 0; pb = 0; pe = 0; ub = 0; ue = 0; wb = 0; we = 0;
    colon = find_first(0, len, CH_COLON);
    if (colon >= len) begin fail(STAT_SCHEME, SCH_NONE); return; end
    for (code = 0; code < NUM_SCHEMES; code++) begin
      if (code == SCH_NOTMUCH && !notmuch_on) continue;
      nm = scheme_names[code];
      if (nm.len() != colon) continue;
      same = 1;
      for (int i = 0; i < colon; i++) begin
        c = text_mem[i];
        if (c >= "A" && c <= "Z") c = c + 32;
        if (c != nm[i]) begin same = 0; break; end
      end
      if (same) break;
    end
    if (code >= NUM_SCHEMES) begin fail(STAT_SCHEME, SCH_NONE); return; end

    s = colon + 1;
    // no "//": the rest is only a path
    if (len - s < 2 || text_mem[s] != CH_SLASH || text_mem[s+1] != CH_SLASH) begin
      if (!escapes_ok(s, len)) begin fail(STAT_PERCENT, code); return; end
      decode_span(s, len, COMP_PATH, 0);
      put(KIND_SUM, COMP_USER, 0, 0, STAT_OK, code, 0, 0);
      return;
    end
    s += 2;
    e = len;
    if (code == SCH_MAILTO || code == SCH_NOTMUCH) begin
      t = find_last(s, e, CH_QM);
      if (t < e) begin
        has_q = 1; qb = t + 1; qe = e; e = t;
        if (!query_pass(qb, qe, 0)) begin fail(STAT_PERCENT, code); return; end
      end
    end
    t = find_first(s, e, CH_SLASH);
    if (t < e) begin
      has_p = 1; pb = t + 1; pe = e; e = t;
      if (!escapes_ok(pb, pe)) begin fail(STAT_PERCENT, code); return; end
    end
    t = find_last(s, e, CH_AT);
    if (t < e) begin
      c2 = find_first(s, t, CH_COLON);
      ub = s; ue = c2;
      if (c2 < t) begin
        has_w = 1; wb = c2 + 1; we = t;
        if (!escapes_ok(wb, we)) begin fail(STAT_PERCENT, code); return; end
      end
      if (!escapes_ok(ub, ue)) begin fail(STAT_PERCENT, code); return; end
      s = t + 1;
    end
    hb = s; he = e; t = s;
    if (s < e && text_mem[s] == CH_LBR) begin
      rb = find_first(s + 1, e, CH_RBR);
      if (rb < e) begin hb = s + 1; he = rb; t = rb + 1; end
    end
    pc = find_first(t, e, CH_COLON);
    if (pc < e) begin
      for (int i = pc + 1; i < e; i++) begin
        c = text_mem[i];
        if (c < CH_0 || c > CH_9) begin fail(STAT_PORT, code); return; end
        port = port * 10 + (c - CH_0);
        if (port > 32'hffff) begin fail(STAT_PORT, code); return; end
      end
      if (t == s) he = pc;
    end
    if (he > hb && !escapes_ok(hb, he)) begin fail(STAT_PERCENT, code); return; end

    decode_span(ub, ue, COMP_USER, 0);
    if (has_w) decode_span(wb, we, COMP_PASS, 0);
    decode_span(hb, he, COMP_HOST, 0);
    if (has_p) begin
      if (he <= hb) put_byte(COMP_PATH, 0, CH_SLASH);
      decode_span(pb, pe, COMP_PATH, 0);
    end
    if (has_q) void'(query_pass(qb, qe, 1));
    put(KIND_SUM, COMP_USER, 0, 0, STAT_OK, code, port[15:0], he > hb);
  endfunction

  function void note_input(bit [7:0] b, bit lst);
    if (loaded < MAX_URL_BYTES) begin
      text_mem[loaded] = b;
      loaded++;
    end else begin
      overflow = 1;
    end
    if (!lst) return;
    run_q.delete();
    if (overflow) fail(STAT_LONG, SCH_NONE);
    else split_url(loaded);
    foreach (run_q[i]) expected_q.push_back(run_q[i]);
    loaded = 0;
    overflow = 0;
  endfunction

  function void report(string what);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, what);
  endfunction

  function void check_result(bit [TDATA_W-1:0] d, bit user, bit lst);
    url_item_t x, a;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected request tdata=%h tuser=%b tlast=%b", d, user, lst));
      return;
    end
    x = expected_q.pop_front();
    a.kind = user; a.comp = d[2:0]; a.qnum = d[7:3]; a.dbyte = d[15:8];
    a.status = d[18:16]; a.scheme = d[22:19]; a.port = d[38:23]; a.has_host = d[39];
    a.lst = lst;
    if (a.kind != x.kind || a.comp != x.comp || a.qnum != x.qnum || a.dbyte != x.dbyte ||
        a.status != x.status || a.scheme != x.scheme || a.port != x.port ||
        a.has_host != x.has_host || a.lst != x.lst)
      report($sformatf({"kind/comp/qn/byte/status/scheme/port/host/last exp ",
                        "%0d/%0d/%0d/%h/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%h/%0d/%0d/%0d/%0d/%0d"},
                       x.kind, x.comp, x.qnum, x.dbyte, x.status, x.scheme, x.port,
                       x.has_host, x.lst, a.kind, a.comp, a.qnum, a.dbyte, a.status,
                       a.scheme, a.port, a.has_host, a.lst));
  endfunction
endclass

module tb;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;  // several passes over a full buffer

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_data_i;
  logic               cfg_ready_o;
  logic [7:0]         s_axis_tdata;
  logic               s_axis_tlast;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tuser;
  logic               m_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready;

  url_scoreboard url_sb;
  bit            idling_on;   // cleared for a long burst with no gaps on either side
  int            bytes_sent;
  int            quiet_cycles;

  url_component_splitter dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_data_i, .cfg_ready_o,
    .s_axis_tdata, .s_axis_tlast, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tlast, .m_axis_tvalid, .m_axis_tready
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // sink: random back-pressure, changed on the falling edge
  always @(negedge clk_i) begin
    m_axis_tready <= !(idling_on && $urandom_range(99) < 33);
  end

  // result requests are checked on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      url_sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // no handshake of any kind for too long ends the run
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // called on a falling edge; returns on the falling edge after acceptance
  task automatic send_byte(bit [7:0] b, bit lst);
    while (idling_on && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    url_sb.note_input(b, lst);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_url(bit [7:0] txt[$]);
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
  endtask

  task automatic send_str(string s);
    bit [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_url(q);
  endtask

  // drain every pending request, let the parser settle, then write the register
  task automatic set_notmuch(bit en);
    s_axis_tvalid <= 1'b0;
    while (url_sb.expected_q.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= en;
    do @(posedge clk_i); while (!cfg_ready_o);
    url_sb.notmuch_on = en;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic string rnd_text(int maxlen);
    string s, alpha;
    int n, k;
    alpha = "abzXY09-.=&:[]@?/";
    s = "";
    n = $urandom_range(maxlen);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 8) s = {s, "%4", (k < 6) ? "1" : "g"};     // good or bad escape
      else if (k < 11) s = {s, "%"};
      else if (k < 60) s = {s, string'(alpha[$urandom_range(7)])};
      else s = {s, string'(alpha[$urandom_range(alpha.len() - 1)])};
    end
    return s;
  endfunction

  // mostly well-formed URLs with random content, some mangled, some noise
  task automatic send_random_url();
    string s, sch;
    bit [7:0] q[$];
    int k;
    k = $urandom_range(99);
    if (k < 8) begin
      repeat ($urandom_range(1, 36)) q.push_back($urandom_range(255));
      send_url(q);
      return;
    end
    sch = (k < 14) ? "bogus" : url_sb.scheme_names[$urandom_range(NUM_SCHEMES - 1)];
    if ($urandom_range(3) == 0) sch = sch.toupper();
    k = $urandom_range(9);
    s = {sch, (k < 8) ? "://" : (k == 8) ? ":" : ":/"};
    if ($urandom_range(1)) s = {s, rnd_text(3), $urandom_range(1) ? {":", rnd_text(3)} : "", "@"};
    if ($urandom_range(9) < 3) s = {s, "[", rnd_text(4), "]"};
    else s = {s, rnd_text(4)};
    k = $urandom_range(9);
    if (k < 2) s = {s, ":", $sformatf("%0d", $urandom_range(99999))};
    else if (k == 2) s = {s, ":", rnd_text(3)};
    if ($urandom_range(9) < 4) s = {s, "/", rnd_text(4)};
    if ($urandom_range(1)) s = {s, "?", rnd_text(3), "=", rnd_text(3), "&", rnd_text(3)};
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    if ($urandom_range(9) == 0) q[$urandom_range(q.size() - 1)] = $urandom_range(255);
    send_url(q);
  endtask

  initial begin
    bit [7:0] q[$];
    url_sb        = new();
    idling_on     = 1'b1;
    bytes_sent    = 0;
    quiet_cycles  = 0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: notmuch off
    set_notmuch(1'b0);
    send_str("notmuch://x?a=b");                    // unknown while disabled
    send_str("File:a%2fb");                         // no "//": all path
    send_str("imaps://us%41:pw@[::1]:993/p%7e");
    send_str("MAILTO://h?a=1&&b&c=%00&");           // empty pair, bare name, trailing &
    send_str("pop://h:65535");
    send_str("pop://h:65536");                      // port too large
    send_str("smtp://h:9x");
    send_str("news:///only/path");                  // empty host, slash re-inserted
    send_str("snews://u@h/%4");                     // broken escape
    send_str("noscheme");
    send_str("[]:x");
    q = {"f", "i", "l", "e", ":", 8'h00, 8'hff};    // raw zero and all-ones bytes
    send_url(q);
    send_str("smtps://abcdefghijklmnopqrstuvwxyz0123"); // overlong
    // directed: notmuch on
    set_notmuch(1'b1);
    send_str("notmuch://?tag=in%62ox&q");
    send_str("notmuch://h?x%zz");

    // random phases, extremes of the register in turn
    for (int ph = 0; ph < 3; ph++) begin
      if (ph > 0) set_notmuch(ph == 1 ? 1'b0 : 1'b1);
      while (bytes_sent < 150 * (ph + 1) + 30) begin
        idling_on = !(ph == 1 && bytes_sent > 240 && bytes_sent < 330);
        send_random_url();
      end
    end

    s_axis_tvalid <= 1'b0;
    idling_on = 1'b1;
    while (url_sb.expected_q.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (url_sb.expected_q.size() > 0) url_sb.report("expected requests never arrived");
    if (url_sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
